// File: rtl/core/crc16_configurable_msb_first_top_defines.svh
// Assertion macros used by the CRC-16 core RTL.
`ifndef CRC16_CONFIGURABLE_MSB_FIRST_TOP_DEFINES_SVH
`define CRC16_CONFIGURABLE_MSB_FIRST_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising edge, off during reset.
`define CRC16_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define CRC16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CRC16_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CRC16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/crc16_pkg.sv
// Shared types, constants and the byte-wise CRC function.
`timescale 1ns / 1ps
package crc16_pkg;

	localparam int CRC_W  = 16;
	localparam int BYTE_W = 8;
	localparam int APB_DW = 32;
	localparam int APB_AW = 4;

	localparam logic [CRC_W-1:0] CRC_TOP_BIT    = 16'h8000;
	localparam logic [CRC_W-1:0] POLY_RESET     = 16'h1021;
	localparam logic [CRC_W-1:0] INIT_RESET     = 16'hFFFF;
	localparam logic [CRC_W-1:0] MASK_RESET     = 16'hFFFF;

	typedef logic [CRC_W-1:0]  crc_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// Register word index (paddr[3:2]).
	typedef enum logic [1:0] {
		REG_POLY = 2'd0,
		REG_INIT = 2'd1,
		REG_MASK = 2'd2
	} reg_idx_t;

	typedef struct packed {
		crc_t polynomial;
		crc_t init_value;
		crc_t final_mask;
	} cfg_t;

	// One byte through the MSB-first shift register: eight unrolled steps.
	function automatic crc_t crc16_byte(input crc_t crc, input byte_t data, input crc_t poly);
		crc_t c;
		c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			if ((c & CRC_TOP_BIT) != '0) begin
				c = {c[CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/core/crc16_if.sv
// Valid/ready channel interfaces for message bytes and CRC results.
`timescale 1ns / 1ps
interface crc16_in_if;
	logic                   valid;
	logic                   ready;
	logic [7:0]             data_byte;
	logic                   last_byte;
	logic                   empty_message;

	modport source (output valid, output data_byte, output last_byte,
		output empty_message, input ready);
	modport sink (input valid, input data_byte, input last_byte,
		input empty_message, output ready);
endinterface

interface crc16_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] crc_value;

	modport source (output valid, output crc_value, input ready);
	modport sink (input valid, input crc_value, output ready);
endinterface

// File: rtl/core/crc16_regs.sv
// APB-style configuration registers: polynomial, init value, final mask.
`timescale 1ns / 1ps
module crc16_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crc16_pkg::APB_AW-1:0]  paddr,
	input  logic [crc16_pkg::APB_DW-1:0]  pwdata,
	output logic [crc16_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	output crc16_pkg::cfg_t               cfg
);
	import crc16_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polynomial <= POLY_RESET;
			cfg_q.init_value <= INIT_RESET;
			cfg_q.final_mask <= MASK_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_POLY: cfg_q.polynomial <= pwdata[CRC_W-1:0];
				REG_INIT: cfg_q.init_value <= pwdata[CRC_W-1:0];
				REG_MASK: cfg_q.final_mask <= pwdata[CRC_W-1:0];
				default: ;  // unmapped word, write dropped
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_POLY: prdata = {{(APB_DW-CRC_W){1'b0}}, cfg_q.polynomial};
			REG_INIT: prdata = {{(APB_DW-CRC_W){1'b0}}, cfg_q.init_value};
			REG_MASK: prdata = {{(APB_DW-CRC_W){1'b0}}, cfg_q.final_mask};
			default:  prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/crc16_core.sv
// Input register, byte-wide CRC update and result register.
`timescale 1ns / 1ps
`include "crc16_configurable_msb_first_top_defines.svh"
module crc16_core (
	input  logic            clk,
	input  logic            arst_n,
	input  crc16_pkg::cfg_t cfg,
	crc16_in_if.sink        in_ch,
	crc16_out_if.source     out_ch
);
	import crc16_pkg::*;

	// input stage
	logic  valid_s1;
	byte_t data_s1;
	logic  last_s1;
	logic  empty_s1;

	// message state
	crc_t  crc_q;
	logic  mid_q;

	// result register
	logic  out_valid_q;
	crc_t  result_q;

	crc_t  crc_start;
	crc_t  crc_next;
	logic  emits;
	logic  out_free;
	logic  adv;
	logic  in_acc;

	assign crc_start = mid_q ? crc_q : cfg.init_value;
	assign crc_next  = crc16_byte(crc_start, data_s1, cfg.polynomial);
	assign emits     = empty_s1 || last_s1;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign adv       = valid_s1 && (!emits || out_free);
	assign in_acc    = in_ch.valid && in_ch.ready;

	assign in_ch.ready      = !valid_s1 || adv;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.crc_value = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			crc_q       <= '0;
			mid_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end

			if (adv) begin
				if (empty_s1) begin
					mid_q <= 1'b0;  // abandons any partial message
				end else begin
					crc_q <= crc_next;
					mid_q <= !last_s1;
				end
			end

			if (adv && emits) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1  <= in_ch.data_byte;
			last_s1  <= in_ch.last_byte;
			empty_s1 <= in_ch.empty_message;
		end
		if (adv && emits) begin
			result_q <= empty_s1 ? ~cfg.init_value : (crc_next & cfg.final_mask);
		end
	end

	`CRC16_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_acc, valid_s1)
	`CRC16_ASSERT_NEXT(a_empty_result, clk, arst_n, adv && empty_s1,
		out_valid_q && (result_q == $past(~cfg.init_value)))
	`CRC16_ASSERT_NEXT(a_end_clears_mid, clk, arst_n, adv && emits, !mid_q)
	`CRC16_ASSERT_IMPL(a_stall_holds_s1, clk, arst_n,
		valid_s1 && emits && out_valid_q && !out_ch.ready, !adv)

endmodule

// File: rtl/core/crc16_configurable_msb_first_top.sv
// Top level of the configurable MSB-first CRC-16 engine.
`timescale 1ns / 1ps
// Configurable CRC-16, MSB first. Message bytes enter on in_ch, one beat per
// byte; a beat with last_byte set closes the message and yields one result
// beat on out_ch carrying the CRC ANDed with final_mask (an AND, not the
// customary XOR). A beat with empty_message set yields ~init_value unmasked
// and drops any message in progress. The engine takes one byte per clock
// cycle, sustained while no closing byte waits on a full output register:
// a beat is captured in an input register, then the eight polynomial steps
// run as one unrolled XOR network into the running CRC and the result
// register. A result waiting in the output register does not stop bytes
// that close no message; only a closing byte waits for it.
// Registers (APB, 32-bit words): 0x0 polynomial (reset 0x1021), 0x4
// init_value (reset 0xFFFF), 0x8 final_mask (reset 0xFFFF); write them only
// while the engine is idle. init_value is sampled at the first byte of each
// message.
module crc16_configurable_msb_first_top (
	input  logic                          clk,
	input  logic                          arst_n,
	crc16_in_if.sink                      in_ch,
	crc16_out_if.source                   out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crc16_pkg::APB_AW-1:0]  paddr,
	input  logic [crc16_pkg::APB_DW-1:0]  pwdata,
	output logic [crc16_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);
	import crc16_pkg::*;

	cfg_t cfg;

	// config register file
	crc16_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// byte datapath
	crc16_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// File: tb/tb_crc16_configurable_msb_first_top.sv
// Self-checking testbench for the configurable MSB-first CRC-16 engine.
`timescale 1ns / 1ps
module tb_crc16_configurable_msb_first_top;
	import crc16_pkg::*;

	// Word index 3 decodes to no register; writes there must change nothing.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// A byte that closes no message can still sit in the input register after
	// the last result, so wait SETTLE_CYCLES before touching registers.
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_BEATS  = 1200;

	logic clk = 1'b0;
	logic arst_n;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	crc16_in_if  in_ch ();
	crc16_out_if out_ch ();

	crc16_configurable_msb_first_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the engine: register copies and message state.
	crc_t poly_m;
	crc_t init_m;
	crc_t mask_m;
	crc_t run_crc;
	logic in_msg;

	crc_t        crc_expected_q [$];
	int unsigned fail_count = 0;
	int unsigned beats_sent = 0;
	int unsigned cycle_count = 0;
	// When set, neither side inserts idle cycles.
	bit          quiet_gaps = 1'b0;

	// Bit-serial form of the MSB-first division: feedback is the top CRC bit
	// XORed with the incoming data bit, taken from bit 7 down.
	function automatic crc_t crc_shift_byte(input crc_t seed, input byte_t b,
		input crc_t poly);
		crc_t acc;
		logic fb;
		acc = seed;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb  = acc[CRC_W-1] ^ b[i];
			acc = {acc[CRC_W-2:0], 1'b0};
			if (fb) begin
				acc = acc ^ poly;
			end
		end
		return acc;
	endfunction

	// Advance the shadow by one accepted beat and queue any result it causes.
	function automatic void predict_beat(input byte_t b, input logic last,
		input logic empty);
		crc_t nxt;
		if (empty) begin
			// Empty message wins over everything and drops a partial message.
			in_msg = 1'b0;
			crc_expected_q.push_back(~init_m);
		end else begin
			nxt     = crc_shift_byte(in_msg ? run_crc : init_m, b, poly_m);
			run_crc = nxt;
			in_msg  = !last;
			if (last) begin
				// AND with the mask, not the usual XOR.
				crc_expected_q.push_back(nxt & mask_m);
			end
		end
	endfunction

	// Result checker and output-side backpressure.
	always @(posedge clk) begin : crc_checker
		crc_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (crc_expected_q.size() == 0) begin
				$error("crc_value: beat with no expected result, actual %h",
					out_ch.crc_value);
				fail_count++;
			end else begin
				want = crc_expected_q.pop_front();
				if (out_ch.crc_value !== want) begin
					$error("crc_value: expected %h actual %h", want, out_ch.crc_value);
					fail_count++;
				end
			end
		end
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= quiet_gaps || ($urandom_range(0, 99) >= 9);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Push one beat through the input channel. valid stays high after the
	// beat so back-to-back beats need no toggle; a gap lowers it.
	task automatic send_beat(input byte_t data, input logic last, input logic empty);
		while (!quiet_gaps && $urandom_range(0, 99) < 9) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.data_byte     <= data;
		in_ch.last_byte     <= last;
		in_ch.empty_message <= empty;
		do begin
			@(posedge clk);
		end while (in_ch.ready !== 1'b1);
		predict_beat(data, last, empty);
		beats_sent++;
	endtask

	// Hold the input off until every queued result has been taken.
	task automatic wait_results_drained();
		in_ch.valid <= 1'b0;
		while (crc_expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle held until pready.
	task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_POLY: poly_m = value[CRC_W-1:0];
			REG_INIT: init_m = value[CRC_W-1:0];
			REG_MASK: mask_m = value[CRC_W-1:0];
			default: ;
		endcase
	endtask

	// Program all three registers at a message boundary with nothing in flight.
	task automatic program_regs(input crc_t poly, input crc_t init, input crc_t mask);
		wait_results_drained();
		apb_write(REG_POLY, {16'($urandom_range(0, 65535)), poly});
		apb_write(REG_INIT, {16'($urandom_range(0, 65535)), init});
		apb_write(REG_MASK, {16'($urandom_range(0, 65535)), mask});
	endtask

	// Mostly random register values, with all-zero and all-one often.
	function automatic crc_t pick_reg_value();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		if (sel == 0) begin
			return '0;
		end else if (sel == 1) begin
			return '1;
		end
		return crc_t'($urandom);
	endfunction

	// Reset values: single-byte extremes, the classic nine-digit check
	// string, empty messages with stray fields, and an abandoned message.
	task automatic test_reset_defaults();
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		for (int i = 0; i < 9; i++) begin
			send_beat(byte_t'(8'h31 + i), i == 8, 1'b0);
		end
		send_beat(8'hA5, 1'b0, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b1);
		// Partial message dropped by an empty beat; next byte starts fresh.
		send_beat(8'h12, 1'b0, 1'b0);
		send_beat(8'h34, 1'b0, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h56, 1'b1, 1'b0);
	endtask

	// Register extremes, plus a write to the unmapped word.
	task automatic test_register_extremes();
		program_regs(16'h0000, 16'h0000, 16'h0000);
		send_beat(8'h80, 1'b1, 1'b0);
		send_beat(8'h3C, 1'b1, 1'b1);
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(8'h80, 1'b0, 1'b0);
		send_beat(8'h01, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		program_regs(16'h8005, 16'h1D0F, 16'h00FF);
		apb_write(REG_UNUSED, 32'hFFFF_FFFF);
		send_beat(8'hC3, 1'b0, 1'b0);
		send_beat(8'h7E, 1'b1, 1'b0);
		send_beat(8'h5A, 1'b0, 1'b1);
	endtask

	// Random messages over several register settings. Mostly whole messages,
	// some bare empty beats, some messages cut short by an empty beat. One
	// phase runs with no idling on either side; occasional full drains.
	task automatic test_random_traffic();
		int unsigned phase_end;
		int unsigned kind;
		int unsigned len;
		for (int phase = 0; phase < 8; phase++) begin
			program_regs(pick_reg_value(), pick_reg_value(), pick_reg_value());
			if ($urandom_range(0, 3) == 0) begin
				apb_write(REG_UNUSED, $urandom);
			end
			quiet_gaps = (phase == 3);
			phase_end  = beats_sent + RANDOM_BEATS / 8;
			while (beats_sent < phase_end) begin
				kind = $urandom_range(0, 99);
				if (kind < 8) begin
					send_beat(byte_t'($urandom), 1'($urandom), 1'b1);
				end else if (kind < 15) begin
					len = $urandom_range(1, 6);
					for (int i = 0; i < len; i++) begin
						send_beat(byte_t'($urandom), 1'b0, 1'b0);
					end
					send_beat(byte_t'($urandom), 1'($urandom), 1'b1);
				end else begin
					len = $urandom_range(1, 12);
					for (int i = 0; i < len; i++) begin
						send_beat(byte_t'($urandom), i == len - 1, 1'b0);
					end
				end
				if ($urandom_range(0, 19) == 0) begin
					wait_results_drained();
				end
			end
			quiet_gaps = 1'b0;
		end
	endtask

	initial begin
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		in_ch.valid         <= 1'b0;
		in_ch.data_byte     <= '0;
		in_ch.last_byte     <= 1'b0;
		in_ch.empty_message <= 1'b0;
		poly_m  = POLY_RESET;
		init_m  = INIT_RESET;
		mask_m  = MASK_RESET;
		run_crc = '0;
		in_msg  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();

		// Let the tail drain; the watchdog bounds this.
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (crc_expected_q.size() != 0) begin
			$error("crc_value: %0d expected results never arrived",
				crc_expected_q.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
